/* rtl/eaq_pkg.sv */
`timescale 1ns / 1ps

package eaq_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int OUT_FRAC_BITS_DEF   = 14;

    localparam int LIM_PITCH_DEG = 180;
    localparam int LIM_YAW_DEG   = 90;
    localparam int LIM_ROLL_DEG  = 180;

    localparam int          TRIG_BITS = 30;
    localparam logic [30:0] TRIG_ONE  = 31'h4000_0000;
    localparam logic [31:0] PI_Q30    = 32'd3373259426;

    // 360 << F = 45 << (3 + F): split the angle magnitude as 45 * u + v
    localparam int DIV45       = 45;
    localparam int DIV45_RECIP = 46604;
    localparam int DIV45_SHIFT = 21;

    typedef logic [31:0] t_etab [0:DIV45-1];

    function automatic t_etab build_etab();
        t_etab tab;
        for (int v = 0; v < DIV45; v++) begin
            tab[v] = 32'((64'(v) * 64'(PI_Q30)) / 64'(DIV45));
        end
        return tab;
    endfunction

    // floor(v * pi_q30 / 45) for each residue v
    localparam t_etab ETAB = build_etab();

    localparam int SIN_STEPS = 6;
    localparam int COS_STEPS = 7;
    localparam int SIN_DIV [0:SIN_STEPS-1] = '{156, 110, 72, 42, 20, 6};
    localparam int COS_DIV [0:COS_STEPS-1] = '{182, 132, 90, 56, 30, 12, 2};

    localparam int NEST_LAT = 3;
    localparam int PRE_LAT  = 4;
    localparam int TRIG_LAT = PRE_LAT + COS_STEPS * NEST_LAT;
    localparam int COMB_LAT = 4;
    localparam int TOTAL_LAT = TRIG_LAT + COMB_LAT;

    localparam int OUT_W = 16;

    typedef struct packed {
        logic [30:0] smag;
        logic        sneg;
        logic [30:0] cmag;
    } t_trig;

endpackage

/* rtl/eaq_in_if.sv */
`timescale 1ns / 1ps

interface eaq_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_deg;
    logic signed [14:0] yaw_deg;
    logic signed [15:0] roll_deg;

    modport source (output valid, output pitch_deg, output yaw_deg, output roll_deg,
                    input ready);
    modport sink   (input valid, input pitch_deg, input yaw_deg, input roll_deg,
                    output ready);
endinterface

/* rtl/eaq_out_if.sv */
`timescale 1ns / 1ps

interface eaq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

/* rtl/euler_angles_to_quaternion.sv */
`timescale 1ns / 1ps

// Euler angles (X, then Y, then Z) to unit quaternion, Rx * Ry * Rz.
// Input channel i_in carries pitch, yaw and roll in signed fixed-point degrees
// (ANGLE_FRAC_BITS fraction bits); pitch and roll saturate to +-180, yaw to +-90.
// Output channel o_out carries w, x, y, z in signed fixed point with
// OUT_FRAC_BITS fraction bits, one result per input transaction, in order.
// Both channels use valid/ready; a transaction moves when both are high.
// The pipeline does angle scaling and squaring, then the seven-step cosine
// series (the sine series runs alongside and is padded to match), then
// products, sums and rounding. Throughput is one transaction per cycle while
// results on o_out are taken.
// All stages advance together: while the output holds a result that is not
// taken, the pipeline holds and i_in.ready drops; the pipeline also advances
// while the output register is empty. Reset clears the valid bits only.

module euler_angles_to_quaternion #(
    parameter int ANGLE_FRAC_BITS = eaq_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = eaq_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    eaq_in_if.sink       i_in,
    eaq_out_if.source    o_out
);

    localparam int LAT = eaq_pkg::TOTAL_LAT;

    logic [LAT-1:0]     r_vld;
    logic               n_adv;
    logic signed [15:0] n_yaw;
    eaq_pkg::t_trig     n_tx, n_ty, n_tz;
    logic signed [15:0] n_w, n_x, n_y, n_z;

    assign n_adv = !r_vld[LAT-1] || o_out.ready;
    assign n_yaw = {i_in.yaw_deg[14], i_in.yaw_deg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    eaq_half_trig #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .LIM_DEG         (eaq_pkg::LIM_PITCH_DEG)
    ) u_trig_x (
        .i_clk   (i_clk),
        .i_en    (n_adv),
        .i_angle (i_in.pitch_deg),
        .o_trig  (n_tx)
    );

    eaq_half_trig #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .LIM_DEG         (eaq_pkg::LIM_YAW_DEG)
    ) u_trig_y (
        .i_clk   (i_clk),
        .i_en    (n_adv),
        .i_angle (n_yaw),
        .o_trig  (n_ty)
    );

    eaq_half_trig #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .LIM_DEG         (eaq_pkg::LIM_ROLL_DEG)
    ) u_trig_z (
        .i_clk   (i_clk),
        .i_en    (n_adv),
        .i_angle (i_in.roll_deg),
        .o_trig  (n_tz)
    );

    eaq_combine #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_combine (
        .i_clk (i_clk),
        .i_en  (n_adv),
        .i_x   (n_tx),
        .i_y   (n_ty),
        .i_z   (n_tz),
        .o_w   (n_w),
        .o_x   (n_x),
        .o_y   (n_y),
        .o_z   (n_z)
    );

    assign i_in.ready   = n_adv;
    assign o_out.valid  = r_vld[LAT-1];
    assign o_out.quat_w = n_w;
    assign o_out.quat_x = n_x;
    assign o_out.quat_y = n_y;
    assign o_out.quat_z = n_z;

endmodule

/* rtl/eaq_nest_step.sv */
`timescale 1ns / 1ps

// t' = ONE - round(x2 * t / (K * ONE)), floored at zero
module eaq_nest_step #(
    parameter int K = 2
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x2,
    input  logic [30:0] i_t,
    output logic [31:0] o_x2,
    output logic [30:0] o_t
);

    localparam int          L      = $clog2(K);
    localparam int          SHIFT  = 32 + L;
    localparam logic [32:0] RECIP  = 33'(((65'd1 << SHIFT) + 65'(K) - 65'd1) / 65'(K));
    localparam logic [32:0] HALF_K = 33'(K / 2);

    logic [61:0] r_p;
    logic [31:0] r_xa;
    logic [65:0] r_prod;
    logic [31:0] r_xb;
    logic [30:0] r_t;
    logic [31:0] r_xc;

    logic [32:0] n_n;
    logic [65:0] n_q;

    // K is even, so the rounding term is K/2 after the shift
    assign n_n = 33'(r_p[61:30]) + HALF_K;
    assign n_q = r_prod >> SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= 62'(i_x2) * 62'(i_t);
            r_xa   <= i_x2;
            r_prod <= 66'(n_n) * 66'(RECIP);
            r_xb   <= r_xa;
            r_t    <= (n_q >= 66'(eaq_pkg::TRIG_ONE)) ? '0 : eaq_pkg::TRIG_ONE - n_q[30:0];
            r_xc   <= r_xb;
        end
    end

    assign o_x2 = r_xc;
    assign o_t  = r_t;

endmodule

/* rtl/eaq_half_trig.sv */
`timescale 1ns / 1ps

module eaq_half_trig #(
    parameter int ANGLE_FRAC_BITS = eaq_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int LIM_DEG         = eaq_pkg::LIM_PITCH_DEG
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [15:0]   i_angle,
    output eaq_pkg::t_trig       o_trig
);

    localparam logic signed [31:0] LIM     = 32'(LIM_DEG << ANGLE_FRAC_BITS);
    localparam logic [31:0]        RND_R   = 32'(1) << (2 + ANGLE_FRAC_BITS);
    localparam int                 R_SHIFT = 3 + ANGLE_FRAC_BITS;
    localparam logic [62:0]        HALF_Q  = 63'(1) << (eaq_pkg::TRIG_BITS - 1);
    localparam int                 SIN_DLY = eaq_pkg::SIN_STEPS * eaq_pkg::NEST_LAT;
    localparam int                 SIN_PAD = (eaq_pkg::COS_STEPS - eaq_pkg::SIN_STEPS)
                                             * eaq_pkg::NEST_LAT - 1;

    // stage 0: saturate, magnitude, scale for the split by 45
    logic signed [31:0] n_a;
    logic signed [31:0] n_sat;
    logic [31:0]        n_mag;
    logic               n_neg;
    logic [15:0]        r_m0;
    logic               r_neg0;
    logic [31:0]        r_um0;

    assign n_a   = signed'({{16{i_angle[15]}}, i_angle});
    assign n_sat = (n_a > LIM) ? LIM : ((n_a < -LIM) ? -LIM : n_a);
    assign n_neg = n_sat[31];
    assign n_mag = n_neg ? 32'(-n_sat) : 32'(n_sat);

    // stage 1: quotient and residue by 45
    logic [9:0]  n_u;
    logic [15:0] n_v16;
    logic [5:0]  n_v;
    logic [9:0]  r_u1;
    logic [31:0] r_e1;
    logic        r_neg1;

    assign n_u   = r_um0[eaq_pkg::DIV45_SHIFT+9:eaq_pkg::DIV45_SHIFT];
    assign n_v16 = r_m0 - 16'(n_u) * 16'(eaq_pkg::DIV45);
    assign n_v   = n_v16[5:0];

    // stage 2: half angle in radians
    logic [42:0] n_acc;
    logic [30:0] r_r2;
    logic        r_neg2;

    assign n_acc = 43'(r_u1) * 43'(eaq_pkg::PI_Q30) + 43'(r_e1);

    // stage 3: square
    logic [62:0] n_sq;
    logic [31:0] r_x2;
    logic [30:0] r_r3;
    logic        r_neg3;

    assign n_sq = 63'(r_r2) * 63'(r_r2) + HALF_Q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0   <= n_mag[15:0];
            r_neg0 <= n_neg;
            r_um0  <= 32'(n_mag[15:0]) * 32'(eaq_pkg::DIV45_RECIP);
            r_u1   <= n_u;
            r_e1   <= eaq_pkg::ETAB[n_v] + RND_R;
            r_neg1 <= r_neg0;
            r_r2   <= 31'(n_acc >> R_SHIFT);
            r_neg2 <= r_neg1;
            r_x2   <= 32'(n_sq >> eaq_pkg::TRIG_BITS);
            r_r3   <= r_r2;
            r_neg3 <= r_neg2;
        end
    end

    // cosine chain
    logic [31:0] n_cx2 [0:eaq_pkg::COS_STEPS];
    logic [30:0] n_ct  [0:eaq_pkg::COS_STEPS];

    assign n_cx2[0] = r_x2;
    assign n_ct[0]  = eaq_pkg::TRIG_ONE;

    for (genvar g = 0; g < eaq_pkg::COS_STEPS; g++) begin : g_cos
        eaq_nest_step #(.K(eaq_pkg::COS_DIV[g])) u_step (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x2  (n_cx2[g]),
            .i_t   (n_ct[g]),
            .o_x2  (n_cx2[g+1]),
            .o_t   (n_ct[g+1])
        );
    end

    // sine chain
    logic [31:0] n_sx2 [0:eaq_pkg::SIN_STEPS];
    logic [30:0] n_st  [0:eaq_pkg::SIN_STEPS];

    assign n_sx2[0] = r_x2;
    assign n_st[0]  = eaq_pkg::TRIG_ONE;

    for (genvar g = 0; g < eaq_pkg::SIN_STEPS; g++) begin : g_sin
        eaq_nest_step #(.K(eaq_pkg::SIN_DIV[g])) u_step (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x2  (n_sx2[g]),
            .i_t   (n_st[g]),
            .o_x2  (n_sx2[g+1]),
            .o_t   (n_st[g+1])
        );
    end

    // hold r and the sign alongside the sine chain
    logic [30:0] r_rd  [0:SIN_DLY-1];
    logic        r_nd  [0:SIN_DLY-1];
    logic [61:0] n_s;
    logic [31:0] n_s30;
    logic [30:0] r_sp  [0:SIN_PAD];
    logic        r_snp [0:SIN_PAD];

    assign n_s   = 62'(r_rd[SIN_DLY-1]) * 62'(n_st[eaq_pkg::SIN_STEPS]) + 62'(HALF_Q);
    assign n_s30 = 32'(n_s >> eaq_pkg::TRIG_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd[0] <= r_r3;
            r_nd[0] <= r_neg3;
            for (int i = 1; i < SIN_DLY; i++) begin
                r_rd[i] <= r_rd[i-1];
                r_nd[i] <= r_nd[i-1];
            end
            if (n_s30 > 32'(eaq_pkg::TRIG_ONE)) begin
                r_sp[0] <= eaq_pkg::TRIG_ONE;
            end else begin
                r_sp[0] <= n_s30[30:0];
            end
            r_snp[0] <= r_nd[SIN_DLY-1] && (n_s30 != '0);
            for (int i = 1; i <= SIN_PAD; i++) begin
                r_sp[i]  <= r_sp[i-1];
                r_snp[i] <= r_snp[i-1];
            end
        end
    end

    assign o_trig.smag = r_sp[SIN_PAD];
    assign o_trig.sneg = r_snp[SIN_PAD];
    assign o_trig.cmag = n_ct[eaq_pkg::COS_STEPS];

endmodule

/* rtl/eaq_combine.sv */
`timescale 1ns / 1ps

module eaq_combine #(
    parameter int OUT_FRAC_BITS = eaq_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  eaq_pkg::t_trig        i_x,
    input  eaq_pkg::t_trig        i_y,
    input  eaq_pkg::t_trig        i_z,
    output logic signed [15:0]    o_w,
    output logic signed [15:0]    o_x,
    output logic signed [15:0]    o_y,
    output logic signed [15:0]    o_z
);

    localparam int          SH     = 2 * eaq_pkg::TRIG_BITS - OUT_FRAC_BITS;
    localparam logic [33:0] LIM    = 34'(1) << OUT_FRAC_BITS;
    localparam logic [33:0] F_MAX  = (34'(1) << (eaq_pkg::OUT_W - 1)) - 34'd1;
    localparam logic [33:0] F_MINM = 34'(1) << (eaq_pkg::OUT_W - 1);

    function automatic logic [30:0] mq(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + (62'(1) << (eaq_pkg::TRIG_BITS - 1));
        return 31'(p >> eaq_pkg::TRIG_BITS);
    endfunction

    function automatic logic signed [62:0] sgnd(input logic [60:0] m, input logic n);
        logic signed [62:0] v;
        v = signed'(63'(m));
        return n ? -v : v;
    endfunction

    function automatic logic [15:0] fin(input logic signed [62:0] s);
        logic        neg;
        logic [62:0] mag;
        logic [62:0] rnd;
        logic [33:0] q;
        logic [15:0] res;
        neg = s[62];
        mag = neg ? 63'(-s) : 63'(s);
        rnd = mag + (63'(1) << (SH - 1));
        q   = 34'(rnd >> SH);
        if (q > LIM) q = LIM;
        if (!neg) begin
            res = (q > F_MAX) ? F_MAX[15:0] : q[15:0];
        end else begin
            res = (q > F_MINM) ? F_MINM[15:0] : 16'(34'd0 - q);
        end
        return res;
    endfunction

    // stage 1: pair products
    logic [30:0] r_cc, r_ss, r_sc, r_cs, r_cz1, r_sz1;
    logic        r_nx1, r_ny1, r_nz1;
    // stage 2: triple products
    logic [60:0] r_ccc, r_sss, r_scc, r_css, r_csc, r_scs, r_ssc, r_ccs;
    logic        r_nx2, r_ny2, r_nz2;
    // stage 3: signed sums
    logic signed [62:0] r_sw, r_sx, r_sy, r_sz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc  <= mq(i_x.cmag, i_y.cmag);
            r_ss  <= mq(i_x.smag, i_y.smag);
            r_sc  <= mq(i_x.smag, i_y.cmag);
            r_cs  <= mq(i_x.cmag, i_y.smag);
            r_cz1 <= i_z.cmag;
            r_sz1 <= i_z.smag;
            r_nx1 <= i_x.sneg;
            r_ny1 <= i_y.sneg;
            r_nz1 <= i_z.sneg;

            r_ccc <= 61'(r_cc) * 61'(r_cz1);
            r_sss <= 61'(r_ss) * 61'(r_sz1);
            r_scc <= 61'(r_sc) * 61'(r_cz1);
            r_css <= 61'(r_cs) * 61'(r_sz1);
            r_csc <= 61'(r_cs) * 61'(r_cz1);
            r_scs <= 61'(r_sc) * 61'(r_sz1);
            r_ssc <= 61'(r_ss) * 61'(r_cz1);
            r_ccs <= 61'(r_cc) * 61'(r_sz1);
            r_nx2 <= r_nx1;
            r_ny2 <= r_ny1;
            r_nz2 <= r_nz1;

            // subtraction flips the sign of the second term
            r_sw <= sgnd(r_ccc, 1'b0) + sgnd(r_sss, !(r_nx2 ^ r_ny2 ^ r_nz2));
            r_sx <= sgnd(r_scc, r_nx2) + sgnd(r_css, r_ny2 ^ r_nz2);
            r_sy <= sgnd(r_csc, r_ny2) + sgnd(r_scs, !(r_nx2 ^ r_nz2));
            r_sz <= sgnd(r_ssc, r_nx2 ^ r_ny2) + sgnd(r_ccs, r_nz2);

            o_w <= signed'(fin(r_sw));
            o_x <= signed'(fin(r_sx));
            o_y <= signed'(fin(r_sy));
            o_z <= signed'(fin(r_sz));
        end
    end

endmodule
